>>> src/v2dc_pkg.sv
`default_nettype none

package v2dc_pkg;

  // Widths of the configuration registers and of the result word.
  localparam int IMAGE_WIDTH_BITS = 11;
  localparam int KERNEL_DIM_BITS  = 3;
  localparam int COEF_REG_BITS    = 60;
  localparam int NUM_COEF_REGS    = 5;
  localparam int TAP_SPACE_BITS   = 64;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int OUT_BITS         = 34;

  localparam logic [IMAGE_WIDTH_BITS-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [KERNEL_DIM_BITS-1:0]  KERNEL_DIM_RESET  = 3'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_KERNEL_ROWS = 3'd1,
    REG_KERNEL_COLS = 3'd2,
    REG_COEF_ROW_0  = 3'd3,
    REG_COEF_ROW_1  = 3'd4,
    REG_COEF_ROW_2  = 3'd5,
    REG_COEF_ROW_3  = 3'd6,
    REG_COEF_ROW_4  = 3'd7
  } cfg_reg_t;

  // Enables handed from the pipeline control to every tap column.
  typedef struct packed {
    logic shift;
    logic prod_en;
    logic sum_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/valid_2d_correlation_unit.sv
`default_nettype none

// Valid-region 2D correlation of a raster-order image stream with a kernel of up
// to MAX_KERNEL x MAX_KERNEL signed Q1.10 taps (not flipped). One sample word is
// taken per clock when the output side keeps up. A result word passes the first
// stage, window, product, column-sum and output registers after the sample that
// completes its window is accepted. The rate is set by the line store, a single
// memory with one read and one write port that delivers the previous kernel rows
// of one column per accepted sample, and by the chain of tap columns, which
// shifts once per sample. A result is emitted only where the whole window lies
// inside the image; out_row_end marks the sample in the last input column and
// out_frame_done marks the result of the in_frame_end sample. Sums are exact
// and sent as 34-bit two's complement. The line store needs no clearing pass
// after reset. Configuration (index 0 width, 1 kernel rows, 2 kernel columns,
// 3 to 7 coefficient rows, five taps each with column 0 lowest) must only be
// written while no sample is in flight; cfg_ready is always high.
module valid_2d_correlation_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_KERNEL  = 5,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_pixel_value,
  input  wire logic                                 in_frame_end,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [v2dc_pkg::OUT_BITS-1:0]      out_filtered_value,
  output logic                                      out_row_end,
  output logic                                      out_frame_done,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [v2dc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [v2dc_pkg::COEF_REG_BITS-1:0]   cfg_data
);

  import v2dc_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RSW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KIW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int LROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int LW    = LROWS * SAMPLE_BITS;
  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int CSW   = PW + $clog2(MAX_KERNEL);
  localparam int ACC_W = CSW + $clog2(MAX_KERNEL);
  localparam int SUM_W = (ACC_W > OUT_BITS) ? ACC_W : OUT_BITS;

  // Configuration registers.
  logic [IMAGE_WIDTH_BITS-1:0] image_width_r;
  logic [KERNEL_DIM_BITS-1:0]  kernel_rows_r;
  logic [KERNEL_DIM_BITS-1:0]  kernel_cols_r;
  logic [COEF_REG_BITS-1:0]    coef_row_r [NUM_COEF_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RESET;
      kernel_rows_r <= KERNEL_DIM_RESET;
      kernel_cols_r <= KERNEL_DIM_RESET;
      coef_row_r    <= '{default: '0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: image_width_r <= cfg_data[IMAGE_WIDTH_BITS-1:0];
        REG_KERNEL_ROWS: kernel_rows_r <= cfg_data[KERNEL_DIM_BITS-1:0];
        REG_KERNEL_COLS: kernel_cols_r <= cfg_data[KERNEL_DIM_BITS-1:0];
        REG_COEF_ROW_0:  coef_row_r[0] <= cfg_data;
        REG_COEF_ROW_1:  coef_row_r[1] <= cfg_data;
        REG_COEF_ROW_2:  coef_row_r[2] <= cfg_data;
        REG_COEF_ROW_3:  coef_row_r[3] <= cfg_data;
        REG_COEF_ROW_4:  coef_row_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are pulled into the supported range.
  logic [WW-1:0]              img_w;
  logic [KERNEL_DIM_BITS-1:0] k_rows;
  logic [KERNEL_DIM_BITS-1:0] k_cols;

  always_comb begin
    if (image_width_r == '0) begin
      img_w = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      img_w = WW'(MAX_WIDTH);
    end else begin
      img_w = WW'(image_width_r);
    end
    if (kernel_rows_r == '0) begin
      k_rows = KERNEL_DIM_BITS'(1);
    end else if (kernel_rows_r > KERNEL_DIM_BITS'(MAX_KERNEL)) begin
      k_rows = KERNEL_DIM_BITS'(MAX_KERNEL);
    end else begin
      k_rows = kernel_rows_r;
    end
    if (kernel_cols_r == '0) begin
      k_cols = KERNEL_DIM_BITS'(1);
    end else if (kernel_cols_r > KERNEL_DIM_BITS'(MAX_KERNEL)) begin
      k_cols = KERNEL_DIM_BITS'(MAX_KERNEL);
    end else begin
      k_cols = kernel_cols_r;
    end
  end

  // Tap grid in kernel coordinates; taps with no register bits behind them read as zero.
  logic [COEF_BITS-1:0] tap [MAX_KERNEL][MAX_KERNEL];

  for (genvar m = 0; m < MAX_KERNEL; m++) begin : g_tap_row
    for (genvar n = 0; n < MAX_KERNEL; n++) begin : g_tap_col
      if (m < NUM_COEF_REGS && (n + 1) * COEF_BITS <= TAP_SPACE_BITS) begin : g_live
        assign tap[m][n] = COEF_BITS'(TAP_SPACE_BITS'(coef_row_r[m]) >> (n * COEF_BITS));
      end else begin : g_none
        assign tap[m][n] = '0;
      end
    end
  end

  // Column d of the chain holds samples d columns back and row k holds k rows back,
  // so it meets kernel tap (rows-1-k, cols-1-d).
  logic [COEF_BITS-1:0]  cell_coef [MAX_KERNEL][MAX_KERNEL];
  logic [MAX_KERNEL-1:0] cell_used [MAX_KERNEL];

  always_comb begin
    logic [KERNEL_DIM_BITS-1:0] mi;
    logic [KERNEL_DIM_BITS-1:0] ni;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      for (int k = 0; k < MAX_KERNEL; k++) begin
        mi = k_rows - KERNEL_DIM_BITS'(k) - KERNEL_DIM_BITS'(1);
        ni = k_cols - KERNEL_DIM_BITS'(d) - KERNEL_DIM_BITS'(1);
        cell_used[d][k] = (KERNEL_DIM_BITS'(k) < k_rows) && (KERNEL_DIM_BITS'(d) < k_cols);
        if (cell_used[d][k]) begin
          cell_coef[d][k] = tap[mi[KIW-1:0]][ni[KIW-1:0]];
        end else begin
          cell_coef[d][k] = '0;
        end
      end
    end
  end

  // Pipeline enables: a stage moves when the one after it is empty or moving.
  logic s1_v_r, w_v_r, p_v_r, c_v_r, out_valid_r;
  logic en_o, en_c, en_p, en_w, en_s1;
  logic in_acc;

  assign en_o   = !out_valid_r || out_ready;
  assign en_c   = !c_v_r || en_o;
  assign en_p   = !p_v_r || en_c;
  assign en_w   = !w_v_r || en_p;
  assign en_s1  = !s1_v_r || en_w;
  assign in_ready = en_s1;
  assign in_acc = in_valid && en_s1;

  // Raster position of the incoming sample.
  logic [CW-1:0]  col_r;
  logic [RSW-1:0] rows_seen_r;
  logic [CW-1:0]  c_now;
  logic [WW-1:0]  c_next;
  logic           produce_now;
  logic           row_end_now;

  always_comb begin
    if (WW'(col_r) >= img_w) begin
      c_now = '0;
    end else begin
      c_now = col_r;
    end
    c_next      = WW'(c_now) + WW'(1);
    produce_now = ((4'(rows_seen_r) + 4'd1) >= 4'(k_rows)) && (c_next >= WW'(k_cols));
    row_end_now = (c_next == img_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rows_seen_r <= '0;
    end else if (in_acc) begin
      if (in_frame_end) begin
        col_r       <= '0;
        rows_seen_r <= '0;
      end else if (c_next >= img_w) begin
        col_r <= '0;
        if (rows_seen_r < RSW'(MAX_KERNEL - 1)) begin
          rows_seen_r <= rows_seen_r + RSW'(1);
        end
      end else begin
        col_r <= c_next[CW-1:0];
      end
    end
  end

  // First stage: the sample waits here while the line store reads its column.
  logic [SAMPLE_BITS-1:0] s1_x_r;
  logic [CW-1:0]          s1_c_r;
  logic                   s1_prod_r;
  logic                   s1_row_end_r;
  logic                   s1_last_r;
  logic                   fwd_r;
  logic [LW-1:0]          fwd_data_r;
  logic [LW-1:0]          ls_rdata;
  logic [LW-1:0]          ls_rd;
  logic [LW-1:0]          ls_wdata;
  logic                   ls_we;
  logic [SAMPLE_BITS-1:0] vert [MAX_KERNEL];

  assign ls_we = s1_v_r && en_w;

  v2dc_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_c_r),
    .wdata (ls_wdata),
    .re    (in_acc),
    .raddr (c_now),
    .rdata (ls_rdata)
  );

  // When two back-to-back samples share a column (a one-sample-wide image), the
  // second read sees the old contents, so the first sample's write is forwarded.
  assign ls_rd = fwd_r ? fwd_data_r : ls_rdata;

  always_comb begin
    vert[0] = s1_x_r;
    for (int k = 1; k < MAX_KERNEL; k++) begin
      vert[k] = ls_rd[(k - 1) * SAMPLE_BITS +: SAMPLE_BITS];
    end
    for (int k = 0; k < LROWS; k++) begin
      ls_wdata[k * SAMPLE_BITS +: SAMPLE_BITS] = vert[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r       <= in_pixel_value;
      s1_c_r       <= c_now;
      s1_prod_r    <= produce_now;
      s1_row_end_r <= row_end_now;
      s1_last_r    <= in_frame_end;
      fwd_r        <= ls_we && (s1_c_r == c_now);
      fwd_data_r   <= ls_wdata;
    end
  end

  // Later stages carry only the samples that give a result.
  logic w_row_end_r, w_last_r;
  logic p_row_end_r, p_last_r;
  logic c_row_end_r, c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r       <= 1'b0;
      p_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_w) begin
        w_v_r <= s1_v_r && s1_prod_r;
      end
      if (en_p) begin
        p_v_r <= w_v_r;
      end
      if (en_c) begin
        c_v_r <= p_v_r;
      end
      if (en_o) begin
        out_valid_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      w_row_end_r <= s1_row_end_r;
      w_last_r    <= s1_last_r;
    end
    if (en_p && w_v_r) begin
      p_row_end_r <= w_row_end_r;
      p_last_r    <= w_last_r;
    end
    if (en_c && p_v_r) begin
      c_row_end_r <= p_row_end_r;
      c_last_r    <= p_last_r;
    end
  end

  // The chain of tap columns: every accepted sample shifts the window by one column,
  // then each column forms its products and their sum in the next two stages.
  cell_ctrl_t              cell_ctrl;
  logic [SAMPLE_BITS-1:0]  win [MAX_KERNEL][MAX_KERNEL];
  logic signed [CSW-1:0]   col_sum [MAX_KERNEL];

  assign cell_ctrl.shift   = ls_we;
  assign cell_ctrl.prod_en = en_p && w_v_r;
  assign cell_ctrl.sum_en  = en_c && p_v_r;

  for (genvar d = 0; d < MAX_KERNEL; d++) begin : g_col
    if (d == 0) begin : g_head
      v2dc_cell #(
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
      ) u_tap_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .col_in   (vert),
        .coef     (cell_coef[d]),
        .tap_used (cell_used[d]),
        .col_out  (win[d]),
        .col_sum  (col_sum[d])
      );
    end else begin : g_body
      v2dc_cell #(
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
      ) u_tap_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .col_in   (win[d-1]),
        .coef     (cell_coef[d]),
        .tap_used (cell_used[d]),
        .col_out  (win[d]),
        .col_sum  (col_sum[d])
      );
    end
  end

  // Final stage: the column sums are added into the output register.
  logic signed [SUM_W-1:0]    total_nxt;
  logic signed [OUT_BITS-1:0] out_value_r;
  logic                       out_row_end_r;
  logic                       out_frame_done_r;

  always_comb begin
    total_nxt = '0;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      total_nxt = total_nxt + SUM_W'(col_sum[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && c_v_r) begin
      out_value_r      <= total_nxt[OUT_BITS-1:0];
      out_row_end_r    <= c_row_end_r;
      out_frame_done_r <= c_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_row_end        = out_row_end_r;
  assign out_frame_done     = out_frame_done_r;

endmodule

`default_nettype wire

>>> src/v2dc_ram.sv
`default_nettype none

module v2dc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/v2dc_cell.sv
`default_nettype none

module v2dc_cell #(
  parameter int MAX_KERNEL  = 5,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  v2dc_pkg::cell_ctrl_t            ctrl,
  input  wire logic [SAMPLE_BITS-1:0]     col_in [MAX_KERNEL],
  input  wire logic [COEF_BITS-1:0]       coef [MAX_KERNEL],
  input  wire logic [MAX_KERNEL-1:0]      tap_used,
  output logic      [SAMPLE_BITS-1:0]     col_out [MAX_KERNEL],
  output logic signed [SAMPLE_BITS+COEF_BITS+$clog2(MAX_KERNEL)-1:0] col_sum
);

  localparam int PW  = SAMPLE_BITS + COEF_BITS;
  localparam int CSW = PW + $clog2(MAX_KERNEL);

  logic [SAMPLE_BITS-1:0] win_r [MAX_KERNEL];
  logic signed [PW-1:0]   prod_r [MAX_KERNEL];
  logic signed [PW-1:0]   prod_nxt [MAX_KERNEL];
  logic signed [CSW-1:0]  sum_r;
  logic signed [CSW-1:0]  sum_nxt;

  // One vertical column of the window; it moves one place down the chain per sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: '0};
    end else if (ctrl.shift) begin
      win_r <= col_in;
    end
  end

  // Taps outside the active kernel are forced to zero so stale data never leaks in.
  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      if (tap_used[k]) begin
        prod_nxt[k] = PW'($signed(win_r[k])) * PW'($signed(coef[k]));
      end else begin
        prod_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < MAX_KERNEL; k++) begin
      sum_nxt = sum_nxt + CSW'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  assign col_out = win_r;
  assign col_sum = sum_r;

endmodule

`default_nettype wire

>>> src/v2dc_checker.sv
`default_nettype none

module v2dc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [v2dc_pkg::OUT_BITS-1:0]      out_filtered_value,
  input wire logic                               out_row_end,
  input wire logic                               out_frame_done
);

  import v2dc_pkg::*;

  // Words accepted at the input and not yet matched by a delivered result.
  logic [31:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 32'(in_valid && in_ready) - 32'(out_valid && out_ready);
    end
  end

  // A result that waits holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_value)
      && $stable(out_row_end) && $stable(out_frame_done))
    else $error("result word changed while stalled");

  // Every result comes from a sample accepted earlier.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> pending_r != 32'd0)
    else $error("result delivered without a pending sample");

  // With an empty output register nothing can hold the input back.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

  // Reset empties the output.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind valid_2d_correlation_unit v2dc_checker u_v2dc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_value (out_filtered_value),
  .out_row_end        (out_row_end),
  .out_frame_done     (out_frame_done)
);

`default_nettype wire
